### hdl/dezp_pkg.sv
// shared widths, fit coefficients, pipeline record and rounding helper for the effective-z pipeline
`default_nettype none
package dezp_pkg;

  localparam int IN_W      = 17;  // transmission field width
  localparam int RATIO_W   = 17;  // log ratio output field
  localparam int Z_W       = 15;  // effective z output field
  localparam int LOG_FRAC  = 24;  // fraction bits of -log2
  localparam int PW        = 5;   // leading-one position
  localparam int M_W       = 31;  // Q1.30 mantissa
  localparam int NW        = 29;  // -log2 value, 5 integer and 24 fraction bits
  localparam int R24W      = 25;  // ratio moved to Q.24
  localparam int YW        = 27;  // exponent argument
  localparam int TW        = 30;  // taylor term
  localparam int SW        = 33;  // taylor sum
  localparam int VW        = 33;  // term times argument, before division
  localparam int RCP_W     = 34;  // reciprocal of the term index
  localparam int RCP_SH    = 33;
  localparam int Z48W      = 57;  // fit result in Q.48
  localparam int EXP_TERMS = 40;

  localparam logic [Z_W-1:0] Z_MAX = 15'd25600;

  // fit coefficients in Q.24, rounded to nearest
  localparam logic [29:0] CQ_A =
    30'((64'd490410047271 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);
  localparam logic [28:0] CQ_B =
    29'((64'd200870450228 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);
  localparam logic [24:0] CQ_C =
    25'((64'd1380531631 * 64'd16777216 + 64'd500000000) / 64'd1000000000);
  localparam logic [23:0] CE_M =
    24'((64'd9456060664 * 64'd16777216 + 64'd5000000000) / 64'd10000000000);
  localparam logic [25:0] CE_K =
    26'((64'd3306075377 * 64'd16777216 + 64'd500000000) / 64'd1000000000);

  typedef struct packed {
    logic            valid;
    logic [R24W-1:0] r24;
    logic [YW-1:0]   y;
    logic [TW-1:0]   term;
    logic [SW-1:0]   sum;
  } exp_t;

  // Q.48 to Q.8 with round half up, saturated
  function automatic logic [Z_W-1:0] round_sat(input logic [Z48W-1:0] z);
    logic [Z48W:0]    t;
    logic [Z48W-40:0] z8;
    t  = {1'b0, z} + ((Z48W+1)'(1) << 39);
    z8 = t[Z48W:40];
    if (z8 > (Z48W-39)'(Z_MAX)) begin
      return Z_MAX;
    end else begin
      return z8[Z_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

### hdl/dezp_log2.sv
// pipelined -log2 of one transmission value by repeated squaring, one fraction bit per stage
`default_nettype none
module dezp_log2 #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [dezp_pkg::IN_W-1:0] x,
  output logic      [dezp_pkg::NW-1:0]   nl
);
  import dezp_pkg::*;

  logic [M_W-1:0]      m_r    [0:LOG_FRAC];
  logic [PW-1:0]       p_r    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_r [0:LOG_FRAC];
  logic [M_W-1:0]      m_nxt  [1:LOG_FRAC];
  logic                b_nxt  [1:LOG_FRAC];

  logic [PW-1:0]  p0;
  logic [M_W-1:0] m0;
  logic [NW-1:0]  ip;

  // leading one position
  always_comb begin
    p0 = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (x[b]) p0 = PW'(b);
    end
    m0 = M_W'(x) << (PW'(M_W - 1) - p0);
  end

  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     t;
    assign sq = m_r[i-1] * m_r[i-1];
    assign t  = sq[2*M_W-1:M_W-1];
    always_comb begin
      if (t[M_W]) begin
        m_nxt[i] = t[M_W:1];
        b_nxt[i] = 1'b1;
      end else begin
        m_nxt[i] = t[M_W-1:0];
        b_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m0;
      p_r[0]    <= p0;
      frac_r[0] <= '0;
      for (int i = 1; i <= LOG_FRAC; i++) begin
        m_r[i]    <= m_nxt[i];
        p_r[i]    <= p_r[i-1];
        frac_r[i] <= {frac_r[i-1][LOG_FRAC-2:0], b_nxt[i]};
      end
    end
  end

  assign ip = NW'(FRAC_BITS) - NW'(p_r[LOG_FRAC]);
  assign nl = (ip << LOG_FRAC) - NW'(frac_r[LOG_FRAC]);

endmodule
`default_nettype wire

### hdl/dezp_exp_term.sv
// one taylor term of exp: multiply by the argument, divide by the term index, accumulate
`default_nettype none
module dezp_exp_term #(
  parameter int N = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire dezp_pkg::exp_t din,
  output dezp_pkg::exp_t      dout
);
  import dezp_pkg::*;

  localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << RCP_SH) / N);
  localparam logic [5:0]       NC  = 6'(N);

  logic            a_v_r, b_v_r;
  logic [R24W-1:0] a_r24_r, b_r24_r;
  logic [YW-1:0]   a_y_r, b_y_r;
  logic [SW-1:0]   a_sum_r, b_sum_r;
  logic [Z48W-1:0] a_p_r;
  logic [VW-1:0]   b_v33_r;
  logic [VW+RCP_W-1:0] b_p2_r;

  logic [VW-1:0]   v_nxt;
  logic [VW-1:0]   q0;
  logic [VW+5:0]   qn;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   q;

  assign v_nxt = a_p_r[Z48W-1:LOG_FRAC];

  // reciprocal estimate is exact or one short
  assign q0  = b_p2_r[VW+RCP_SH-1:RCP_SH];
  assign qn  = q0 * NC;
  assign rem = b_v33_r - qn[VW-1:0];
  assign q   = (rem >= VW'(N)) ? q0 + VW'(1) : q0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      a_v_r      <= din.valid;
      b_v_r      <= a_v_r;
      dout.valid <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r24_r   <= din.r24;
      a_y_r     <= din.y;
      a_sum_r   <= din.sum;
      a_p_r     <= din.term * din.y;
      b_r24_r   <= a_r24_r;
      b_y_r     <= a_y_r;
      b_sum_r   <= a_sum_r;
      b_v33_r   <= v_nxt;
      b_p2_r    <= v_nxt * RCP;
      dout.r24  <= b_r24_r;
      dout.y    <= b_y_r;
      dout.term <= q[TW-1:0];
      dout.sum  <= b_sum_r + q;
    end
  end

endmodule
`default_nettype wire

### hdl/dual_energy_zeff_pixel_top.sv
// dual-energy pixel: log ratio ln(high)/ln(low) and effective z, fully pipelined
// throughput: one pixel per cycle while the output buffer is not full; pipeline of the 24 squaring stages,
// FRAC_BITS+1 divider stages and 40 three-stage taylor term stages
// whole pipeline stalls together behind a two-entry output buffer
// synchronous reset clears all valid bits; no clearing pass
`default_nettype none
module dual_energy_zeff_pixel_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // low_trans[16:0], high_trans[33:17], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata   // log_ratio[16:0], eff_z[31:17]
);
  import dezp_pkg::*;

  localparam int RW  = FRAC_BITS + 1;
  localparam int DS  = FRAC_BITS + 1;
  localparam int SH  = LOG_FRAC - FRAC_BITS;
  localparam int LAT = LOG_FRAC + 1;
  localparam logic [RW-1:0]   INV_RATIO = RW'((2**FRAC_BITS + 50) / 100);
  localparam logic [RW-1:0]   RATIO_HI  = RW'(3 * 2**(FRAC_BITS-1));
  localparam logic [R24W-1:0] BAND_LO24 = R24W'(2**(FRAC_BITS-1)) << SH;
  localparam logic [R24W-1:0] BAND_HI24 = R24W'((6 * 2**FRAC_BITS) / 5) << SH;

  logic out_v_r, skid_v_r;
  logic en;
  assign en        = !skid_v_r;
  assign in_tready = en;

  logic [IN_W-1:0] lo, hi;
  logic            ok_in;
  assign lo    = in_tdata[16:0];
  assign hi    = in_tdata[33:17];
  assign ok_in = (lo != '0) && (hi != '0) &&
                 (32'(lo) < (32'd1 << FRAC_BITS)) && (32'(hi) < (32'd1 << FRAC_BITS));

  // log stages
  logic [NW-1:0] nl, nh;
  dezp_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_lo (.clk(clk), .en(en), .x(lo), .nl(nl));
  dezp_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_hi (.clk(clk), .en(en), .x(hi), .nl(nh));

  logic vd_r [0:LAT-1];
  logic ok_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r[0] <= ok_in;
      for (int i = 1; i < LAT; i++) ok_r[i] <= ok_r[i-1];
    end
  end

  // restoring divider, one quotient bit per stage
  logic          d_v_r   [0:DS];
  logic          d_bad_r [0:DS];
  logic [NW-1:0] d_nl_r  [0:DS];
  logic [NW:0]   d_rem_r [0:DS];
  logic [RW-1:0] d_q_r   [0:DS];
  logic          d_ge    [0:DS-1];
  logic [NW-1:0] d_rn    [0:DS-1];

  for (genvar k = 0; k < DS; k++) begin : g_div
    assign d_ge[k] = d_rem_r[k] >= {1'b0, d_nl_r[k]};
    assign d_rn[k] = d_ge[k] ? NW'(d_rem_r[k] - {1'b0, d_nl_r[k]}) : d_rem_r[k][NW-1:0];
  end

  logic bad0;
  // quotient of 2^(FRAC_BITS+1) or more is out of range anyway
  assign bad0 = !ok_r[LAT-1] || (nl == '0) || ({1'b0, nh} >= {nl, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DS; k++) d_v_r[k] <= 1'b0;
    end else if (en) begin
      d_v_r[0] <= vd_r[LAT-1];
      for (int k = 0; k < DS; k++) d_v_r[k+1] <= d_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_bad_r[0] <= bad0;
      d_nl_r[0]  <= nl;
      d_rem_r[0] <= {1'b0, nh};
      d_q_r[0]   <= '0;
      for (int k = 0; k < DS; k++) begin
        d_bad_r[k+1] <= d_bad_r[k];
        d_nl_r[k+1]  <= d_nl_r[k];
        d_rem_r[k+1] <= {d_rn[k], 1'b0};
        d_q_r[k+1]   <= {d_q_r[k][RW-2:0], d_ge[k]};
      end
    end
  end

  // ratio check, then exponent argument
  logic [RW-1:0]   r_fin;
  logic            r_v_r, y_v_r;
  logic [R24W-1:0] r_r24_r, y_r24_r;
  logic [50:0]     y_prod_r;

  assign r_fin = (d_bad_r[DS] || (d_q_r[DS] > RATIO_HI) || (d_q_r[DS] == '0)) ?
                 INV_RATIO : d_q_r[DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
      y_v_r <= 1'b0;
    end else if (en) begin
      r_v_r <= d_v_r[DS];
      y_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r24_r  <= R24W'(r_fin) << SH;
      y_r24_r  <= r_r24_r;
      y_prod_r <= CE_K * r_r24_r;
    end
  end

  // taylor chain
  exp_t e [0:EXP_TERMS];
  assign e[0] = '{valid: y_v_r, r24: y_r24_r, y: y_prod_r[50:LOG_FRAC],
                  term: TW'(1) << LOG_FRAC, sum: SW'(1) << LOG_FRAC};

  for (genvar k = 0; k < EXP_TERMS; k++) begin : g_exp
    dezp_exp_term #(.N(k + 1)) u_term (
      .clk(clk), .rst_n(rst_n), .en(en), .din(e[k]), .dout(e[k+1])
    );
  end

  // fits and rounding
  logic            f1_v_r, f2_v_r, f3_v_r;
  logic [Z48W-1:0] f1_ez_r;
  logic [49:0]     f1_sq_r;
  logic [53:0]     f1_neg_r;
  logic            f1_band_r, f2_band_r;
  logic [R24W-1:0] f1_r24_r, f2_r24_r;
  logic [Z_W-1:0]  f2_ze_r;
  logic [Z48W-1:0] f2_pos_r, f2_neg_r;
  logic [55:0]     pos_prod;
  logic [Z48W-1:0] q_diff;
  logic [RATIO_W-1:0] f3_ratio_r;
  logic [Z_W-1:0]     f3_z_r;

  assign pos_prod = CQ_A * f1_sq_r[49:LOG_FRAC];
  assign q_diff   = (f2_neg_r > f2_pos_r) ? '0 : f2_pos_r - f2_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= e[EXP_TERMS].valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ez_r    <= CE_M * e[EXP_TERMS].sum;
      f1_sq_r    <= e[EXP_TERMS].r24 * e[EXP_TERMS].r24;
      f1_neg_r   <= CQ_B * e[EXP_TERMS].r24;
      f1_band_r  <= (e[EXP_TERMS].r24 > BAND_LO24) && (e[EXP_TERMS].r24 < BAND_HI24);
      f1_r24_r   <= e[EXP_TERMS].r24;
      f2_ze_r    <= round_sat(f1_ez_r);
      f2_pos_r   <= Z48W'(pos_prod) + (Z48W'(CQ_C) << LOG_FRAC);
      f2_neg_r   <= Z48W'(f1_neg_r);
      f2_band_r  <= f1_band_r;
      f2_r24_r   <= f1_r24_r;
      f3_z_r     <= f2_band_r ? round_sat(q_diff) : f2_ze_r;
      f3_ratio_r <= RATIO_W'(f2_r24_r >> SH);
    end
  end

  // output register plus skid entry
  logic [31:0] out_d_r, skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= f3_v_r;
    end else if (f3_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) out_d_r <= skid_d_r;
    end else if (!out_v_r || out_tready) begin
      out_d_r <= {f3_z_r, f3_ratio_r};
    end else begin
      skid_d_r <= {f3_z_r, f3_ratio_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry held without output entry");

  a_z_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r[31:17] <= Z_MAX)) else $error("eff_z above saturation");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (out_v_r && !skid_v_r))
    else $error("skid entry not moved to output");

  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_tready && !skid_v_r && !f3_v_r) |=> !out_v_r)
    else $error("output valid without a new result");

endmodule
`default_nettype wire
